>>> design/acpu_pkg.sv
// Shared constants for the 8-bit accumulator CPU: command codes, opcodes,
// run status codes, memory geometry and the saturating counter helper.
// No dependencies.
package acpu_pkg;

  localparam int unsigned MemDepth = 256;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned DataW    = 8;
  localparam int unsigned CntW     = 32;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;

  localparam logic [7:0] OP_NOP = 8'h00;
  localparam logic [7:0] OP_STA = 8'h10;
  localparam logic [7:0] OP_LDA = 8'h20;
  localparam logic [7:0] OP_ADD = 8'h30;
  localparam logic [7:0] OP_OR  = 8'h40;
  localparam logic [7:0] OP_AND = 8'h50;
  localparam logic [7:0] OP_NOT = 8'h60;
  localparam logic [7:0] OP_JMP = 8'h80;
  localparam logic [7:0] OP_JN  = 8'h90;
  localparam logic [7:0] OP_JZ  = 8'hA0;
  localparam logic [7:0] OP_HLT = 8'hF0;

  localparam logic [7:0] SIGN_MASK = 8'h80;

  localparam logic [1:0] RUN_ACTIVE  = 2'd0;
  localparam logic [1:0] RUN_HALTED  = 2'd1;
  localparam logic [1:0] RUN_BAD_OP  = 2'd2;

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] c);
    sat_inc = (c == {CntW{1'b1}}) ? c : c + CntW'(1);
  endfunction

endpackage

>>> design/acpu_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module acpu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/accumulator_cpu_8bit.sv
// Top level of the 8-bit accumulator CPU: sequencer, shared ALU, registers.
// Depends on acpu_pkg and acpu_ram.
// Path from acceptance to result valid: write, ignored and halted-execute transactions go
// straight to RESP; read passes RDATA; NOP/NOT/HLT/bad opcode pass DECODE; STA and jumps
// pass DECODE, OPER; LDA/ADD/OR/AND pass DECODE, OPER, EXEC (one RAM access per cycle).
// One transaction in flight; the next is taken the cycle after the result is registered.
// Reset: asynchronous; memory reads as zero until written (per-byte valid bits).
module accumulator_cpu_8bit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  mem_addr_i,
  input  logic [7:0]  mem_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_byte_o,
  output logic [7:0]  accumulator_o,
  output logic [7:0]  program_counter_o,
  output logic        negative_flag_o,
  output logic        zero_flag_o,
  output logic [1:0]  run_status_o,
  output logic [31:0] instructions_done_o,
  output logic [31:0] access_total_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDATA  = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_OPER   = 3'd3;
  localparam logic [2:0] S_EXEC   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  localparam int unsigned AW = acpu_pkg::AddrW;
  localparam int unsigned DW = acpu_pkg::DataW;
  localparam int unsigned CW = acpu_pkg::CntW;

  logic [2:0]  state_q, state_d;
  logic [DW-1:0] acc_q, acc_d;
  logic [AW-1:0] pc_q, pc_d;
  logic        neg_q, neg_d, zero_q, zero_d;
  logic [1:0]  run_q, run_d;
  logic [CW-1:0] icnt_q, icnt_d, acnt_q, acnt_d;
  logic [DW-1:0] op_q, op_d;
  logic [DW-1:0] rd_q, rd_d;
  logic [acpu_pkg::MemDepth-1:0] valid_q;
  logic        rdv_q;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] ram_wdata, ram_rdata, mem_rd;

  logic [DW-1:0] alu_op, alu_res;

  logic        out_valid_q;
  logic [DW-1:0] o_rd_q, o_acc_q, o_pc_q;
  logic        o_neg_q, o_zero_q;
  logic [1:0]  o_run_q;
  logic [CW-1:0] o_icnt_q, o_acnt_q;
  logic        out_load;
  logic        in_fire;

  acpu_ram #(
    .Width (DW),
    .Depth (acpu_pkg::MemDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign mem_rd     = rdv_q ? ram_rdata : '0;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  // shared ALU: NOT in decode, otherwise the latched opcode against memory data
  assign alu_op = (state_q == S_DECODE) ? acpu_pkg::OP_NOT : op_q;

  always_comb begin
    case (alu_op)
      acpu_pkg::OP_ADD: alu_res = acc_q + mem_rd;
      acpu_pkg::OP_OR:  alu_res = acc_q | mem_rd;
      acpu_pkg::OP_AND: alu_res = acc_q & mem_rd;
      acpu_pkg::OP_NOT: alu_res = ~acc_q;
      default:          alu_res = mem_rd;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    pc_d      = pc_q;
    neg_d     = neg_q;
    zero_d    = zero_q;
    run_d     = run_q;
    icnt_d    = icnt_q;
    acnt_d    = acnt_q;
    op_d      = op_q;
    rd_d      = rd_q;
    ram_we    = 1'b0;
    ram_addr  = pc_q;
    ram_wdata = acc_q;

    case (state_q)
      S_IDLE: begin
        ram_addr = mem_addr_i;
        if (in_fire) begin
          rd_d = '0;
          case (cmd_i)
            acpu_pkg::CMD_WRITE: begin
              ram_we    = 1'b1;
              ram_wdata = mem_data_i;
              state_d   = S_RESP;
            end
            acpu_pkg::CMD_READ: begin
              state_d = S_RDATA;
            end
            acpu_pkg::CMD_EXEC: begin
              if (run_q != acpu_pkg::RUN_ACTIVE) begin
                state_d = S_RESP;
              end else begin
                ram_addr = pc_q;
                pc_d     = pc_q + AW'(1);
                acnt_d   = acpu_pkg::sat_inc(acnt_q);
                state_d  = S_DECODE;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_RDATA: begin
        rd_d    = mem_rd;
        state_d = S_RESP;
      end
      S_DECODE: begin
        op_d    = mem_rd;
        icnt_d  = acpu_pkg::sat_inc(icnt_q);
        state_d = S_RESP;
        case (mem_rd)
          acpu_pkg::OP_NOP: ;
          acpu_pkg::OP_NOT: begin
            acc_d  = alu_res;
            zero_d = (alu_res == '0);
            neg_d  = |(alu_res & acpu_pkg::SIGN_MASK);
          end
          acpu_pkg::OP_HLT: run_d = acpu_pkg::RUN_HALTED;
          acpu_pkg::OP_STA, acpu_pkg::OP_LDA, acpu_pkg::OP_ADD, acpu_pkg::OP_OR,
          acpu_pkg::OP_AND, acpu_pkg::OP_JMP, acpu_pkg::OP_JN, acpu_pkg::OP_JZ: begin
            ram_addr = pc_q;
            pc_d     = pc_q + AW'(1);
            acnt_d   = acpu_pkg::sat_inc(acnt_q);
            state_d  = S_OPER;
          end
          default: run_d = acpu_pkg::RUN_BAD_OP;
        endcase
      end
      S_OPER: begin
        ram_addr = mem_rd;
        state_d  = S_RESP;
        case (op_q)
          acpu_pkg::OP_STA: begin
            ram_we = 1'b1;
            acnt_d = acpu_pkg::sat_inc(acnt_q);
          end
          acpu_pkg::OP_JMP: pc_d = mem_rd;
          acpu_pkg::OP_JN:  if (neg_q) pc_d = mem_rd;
          acpu_pkg::OP_JZ:  if (zero_q) pc_d = mem_rd;
          default: begin
            acnt_d  = acpu_pkg::sat_inc(acnt_q);
            state_d = S_EXEC;
          end
        endcase
      end
      S_EXEC: begin
        acc_d   = alu_res;
        zero_d  = (alu_res == '0);
        neg_d   = |(alu_res & acpu_pkg::SIGN_MASK);
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      pc_q        <= '0;
      neg_q       <= 1'b0;
      zero_q      <= 1'b0;
      run_q       <= acpu_pkg::RUN_ACTIVE;
      icnt_q      <= '0;
      acnt_q      <= '0;
      valid_q     <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      pc_q    <= pc_d;
      neg_q   <= neg_d;
      zero_q  <= zero_d;
      run_q   <= run_d;
      icnt_q  <= icnt_d;
      acnt_q  <= acnt_d;
      rdv_q   <= valid_q[ram_addr];
      if (ram_we) valid_q[ram_addr] <= 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    rd_q <= rd_d;
    if (out_load) begin
      o_rd_q   <= rd_q;
      o_acc_q  <= acc_q;
      o_pc_q   <= pc_q;
      o_neg_q  <= neg_q;
      o_zero_q <= zero_q;
      o_run_q  <= run_q;
      o_icnt_q <= icnt_q;
      o_acnt_q <= acnt_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_byte_o         = o_rd_q;
  assign accumulator_o       = o_acc_q;
  assign program_counter_o   = o_pc_q;
  assign negative_flag_o     = o_neg_q;
  assign zero_flag_o         = o_zero_q;
  assign run_status_o        = o_run_q;
  assign instructions_done_o = o_icnt_q;
  assign access_total_o      = o_acnt_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q != acpu_pkg::RUN_ACTIVE) |=> (run_q == $past(run_q)))
    else $error("halt state left without reset");

  a_icnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (icnt_q == {CW{1'b1}}) |=> (icnt_q == {CW{1'b1}}))
    else $error("instruction counter wrapped");

  a_acnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (acnt_q >= $past(acnt_q)))
    else $error("access counter decreased");

  a_resp_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("result not registered on completion");

endmodule
